### rtl/voice_chip_one_wire_sender_assert.svh
// ----------------------------------------------------------------------------
// voice_chip_one_wire_sender_assert.svh
// Assertion macros used by the one-wire sender RTL.
// ----------------------------------------------------------------------------
`ifndef VOICE_CHIP_ONE_WIRE_SENDER_ASSERT_SVH
`define VOICE_CHIP_ONE_WIRE_SENDER_ASSERT_SVH

// Check a property on every rising edge of clk, quiet while in reset.
`define VCOWS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define VCOWS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vcows_pkg.sv
// ----------------------------------------------------------------------------
// vcows_pkg
// Types, register indexes, reset timings and the label code table for the
// one-wire voice chip command sender.
// ----------------------------------------------------------------------------
package vcows_pkg;

	// Register indexes on the configuration port
	localparam int unsigned REG_W = 2;
	localparam logic [REG_W-1:0] REG_SHORT_PULSE = 2'd0;
	localparam logic [REG_W-1:0] REG_LONG_PULSE  = 2'd1;
	localparam logic [REG_W-1:0] REG_START_LOW   = 2'd2;
	localparam logic [REG_W-1:0] REG_STOP_HIGH   = 2'd3;

	// Timing registers
	localparam int unsigned TICK_W = 16;
	localparam logic [TICK_W-1:0] SHORT_PULSE_RST = 16'd500;
	localparam logic [TICK_W-1:0] LONG_PULSE_RST  = 16'd1500;
	localparam logic [TICK_W-1:0] START_LOW_RST   = 16'd5000;
	localparam logic [TICK_W-1:0] STOP_HIGH_RST   = 16'd50000;

	// Command code
	localparam int unsigned CODE_BITS_DEF = 8;
	localparam int unsigned LABEL_W       = 8;
	localparam int unsigned CMD_W         = 5;

	// Item operations
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PLAY = 1'b1;

	// Line sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_START    = 5'b00010,
		PH_BIT_HIGH = 5'b00100,
		PH_BIT_LOW  = 5'b01000,
		PH_STOP     = 5'b10000
	} phase_t;

	// Map a label character to its one-based command code, 0 if unknown
	function automatic logic [CMD_W-1:0] label_code(input logic [LABEL_W-1:0] lbl);
		logic [CMD_W-1:0] code;
		begin
			case (lbl)
				"1": code = 5'd1;
				"2": code = 5'd2;
				"3": code = 5'd3;
				"4": code = 5'd4;
				"5": code = 5'd5;
				"6": code = 5'd6;
				"7": code = 5'd7;
				"8": code = 5'd8;
				"9": code = 5'd9;
				"0": code = 5'd10;
				".": code = 5'd11;
				"k": code = 5'd12;
				"o": code = 5'd13;
				"b": code = 5'd14;
				"c": code = 5'd15;
				"x": code = 5'd16;
				"z": code = 5'd17;
				"p": code = 5'd18;
				"l": code = 5'd19;
				"s": code = 5'd20;
				default: code = 5'd0;
			endcase
			return code;
		end
	endfunction

	// Treat a zero tick count as one tick
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

endpackage

### rtl/voice_chip_one_wire_sender.sv
// ----------------------------------------------------------------------------
// voice_chip_one_wire_sender
// Sends play commands to a voice chip over its single data line: start low,
// code bits LSB first as long/short pulse pairs, then a high stop guard.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | transfer
//  --------+--------------------------------------------+---------------------
//  in      | in_valid, in_ready, operation, label       | valid & ready
//  out     | out_valid, out_ready, line_level, busy_res,| valid & ready
//          | accepted, label_unknown, refused_busy      |
//  cfg     | cfg_we, cfg_index, cfg_data                | cfg_we
//
//  One item per cycle while out_ready holds; an item passes the input register,
//  then the result register, where its result is offered until it transfers.
//  The sequencer state updates as an item moves from the input register to
//  the result register, so items are handled strictly in order.
//  The input register keeps taking items while a result waits, until it
//  holds one itself.
//  Reset leaves the sequencer idle, the line high and the timings at defaults.
//
module voice_chip_one_wire_sender #(
	parameter int unsigned CODE_BITS = vcows_pkg::CODE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [vcows_pkg::LABEL_W-1:0] label,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         line_level,
	output logic                         busy_res,
	output logic                         accepted,
	output logic                         label_unknown,
	output logic                         refused_busy,
	input  logic                         cfg_we,
	input  logic [vcows_pkg::REG_W-1:0]  cfg_index,
	input  logic [vcows_pkg::TICK_W-1:0] cfg_data
);
	import vcows_pkg::*;

	`include "voice_chip_one_wire_sender_assert.svh"

	localparam int unsigned BIT_W = $clog2(CODE_BITS + 1);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CODE_BITS - 1);

	// Timing registers
	logic [TICK_W-1:0] short_pulse_q, long_pulse_q, start_low_q, stop_high_q;

	// Input register
	logic               valid_s1;
	logic               operation_s1;
	logic [LABEL_W-1:0] label_s1;
	logic               advance;

	// Sequencer state
	phase_t                phase_q, phase_d;
	logic [BIT_W-1:0]      bit_index_q, bit_index_d;
	logic [CODE_BITS-1:0]  shift_q, shift_d;
	logic [TICK_W-1:0]     time_left_q, time_left_d;
	logic                  line_q, line_d;

	// Result register
	logic out_valid_q, line_level_q, busy_q, accepted_q, unknown_q, refused_q;
	logic acc_d, unk_d, ref_d;

	// Lookup of the request label
	logic [CMD_W-1:0]     cmd_code;
	logic [CODE_BITS-1:0] cmd_ext;
	logic [TICK_W-1:0]    tick_dec;

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_pulse_q <= SHORT_PULSE_RST;
			long_pulse_q  <= LONG_PULSE_RST;
			start_low_q   <= START_LOW_RST;
			stop_high_q   <= STOP_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_PULSE: short_pulse_q <= cfg_data;
				REG_LONG_PULSE:  long_pulse_q  <= cfg_data;
				REG_START_LOW:   start_low_q   <= cfg_data;
				REG_STOP_HIGH:   stop_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Move items on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Hold the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1 <= operation;
			label_s1     <= label;
		end
	end

	// Fit the table code to the shift register width
	assign cmd_code = label_code(label_s1);
	for (genvar i = 0; i < CODE_BITS; i++) begin : g_code
		if (i < CMD_W) begin : g_bit
			assign cmd_ext[i] = cmd_code[i];
		end else begin : g_zero
			assign cmd_ext[i] = 1'b0;
		end
	end

	assign tick_dec = (time_left_q != '0) ? time_left_q - TICK_W'(1) : '0;

	// Next sequencer state and flags for the item in the input register
	always_comb begin
		phase_d     = phase_q;
		bit_index_d = bit_index_q;
		shift_d     = shift_q;
		time_left_d = time_left_q;
		line_d      = line_q;
		acc_d       = 1'b0;
		unk_d       = 1'b0;
		ref_d       = 1'b0;
		if (operation_s1 == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				time_left_d = tick_dec;
				if (tick_dec == '0) begin
					case (phase_q)
						PH_START: begin
							phase_d     = PH_BIT_HIGH;
							line_d      = 1'b1;
							time_left_d = at_least_one(shift_q[0] ? long_pulse_q
								: short_pulse_q);
						end
						PH_BIT_HIGH: begin
							phase_d     = PH_BIT_LOW;
							line_d      = 1'b0;
							time_left_d = at_least_one(shift_q[0] ? short_pulse_q
								: long_pulse_q);
						end
						PH_BIT_LOW: begin
							shift_d     = shift_q >> 1;
							bit_index_d = bit_index_q + BIT_W'(1);
							line_d      = 1'b1;
							if (bit_index_q == LAST_BIT) begin
								phase_d     = PH_STOP;
								time_left_d = at_least_one(stop_high_q);
							end else begin
								phase_d     = PH_BIT_HIGH;
								time_left_d = at_least_one(shift_q[1 % CODE_BITS] &&
									(CODE_BITS > 1) ? long_pulse_q : short_pulse_q);
							end
						end
						default: begin
							phase_d     = PH_IDLE;
							line_d      = 1'b1;
							bit_index_d = '0;
							shift_d     = '0;
							time_left_d = '0;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE) begin
			ref_d = 1'b1;
		end else if (cmd_code == '0) begin
			unk_d = 1'b1;
		end else begin
			acc_d       = 1'b1;
			shift_d     = cmd_ext;
			bit_index_d = '0;
			phase_d     = PH_START;
			line_d      = 1'b0;
			time_left_d = at_least_one(start_low_q);
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_index_q <= '0;
			shift_q     <= '0;
			time_left_q <= '0;
			line_q      <= 1'b1;
		end else if (advance) begin
			phase_q     <= phase_d;
			bit_index_q <= bit_index_d;
			shift_q     <= shift_d;
			time_left_q <= time_left_d;
			line_q      <= line_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_level_q <= line_d;
			busy_q       <= (phase_d != PH_IDLE);
			accepted_q   <= acc_d;
			unknown_q    <= unk_d;
			refused_q    <= ref_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_level    = line_level_q;
	assign busy_res      = busy_q;
	assign accepted      = accepted_q;
	assign label_unknown = unknown_q;
	assign refused_busy  = refused_q;

	// Checks
	`VCOWS_ASSERT_ALWAYS(a_idle_quiet,
		(phase_q == PH_IDLE) |-> (line_q && time_left_q == '0),
		"idle sequencer must keep the line high with no time left")
	`VCOWS_ASSERT(a_flags_exclusive,
		out_valid_q |-> $onehot0({accepted_q, unknown_q, refused_q}),
		"more than one request flag set")
	`VCOWS_ASSERT(a_start_low,
		(out_valid_q && accepted_q) |-> (busy_q && !line_level_q),
		"started command must pull the line low and be busy")
	`VCOWS_ASSERT(a_s1_hold,
		(valid_s1 && !advance) |=> (valid_s1 && $stable(label_s1)),
		"stalled input register lost its item")

endmodule
